@@ rtl/dfe_pkg.sv @@
// ---------------------------------------------------------------------------
// Decimal field extractor package
// Shared types and character constants for the decimal field extractor.
// ---------------------------------------------------------------------------
package dfe_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CountWidth = 3;

  localparam logic [CharWidth-1:0]  CharZero   = 8'h30;
  localparam logic [CharWidth-1:0]  CharNine   = 8'h39;
  localparam logic [CountWidth-1:0] NeedSingle = 3'd1;
  localparam logic [CountWidth-1:0] NeedQuad   = 3'd4;
  localparam logic                  QuadReset  = 1'b1;

  typedef struct packed {
    logic [ValueWidth-1:0] acc;
    logic                  in_num;
    logic [CountWidth-1:0] fields;
    logic [ValueWidth-1:0] packed_val;
  } scan_state_t;

endpackage

@@ rtl/dfe_if.sv @@
// ---------------------------------------------------------------------------
// Decimal field extractor channels
// Valid/ready channels for character requests and extracted results.
// ---------------------------------------------------------------------------
interface dfe_in_if;
  logic                           valid;
  logic                           ready;
  logic [dfe_pkg::CharWidth-1:0]  char_code;
  logic                           has_char;
  logic                           last;

  modport source (output valid, output char_code, output has_char, output last, input ready);
  modport sink   (input valid, input char_code, input has_char, input last, output ready);
endinterface

interface dfe_out_if;
  logic                           valid;
  logic                           ready;
  logic [dfe_pkg::ValueWidth-1:0] value;
  logic                           parse_error;

  modport source (output valid, output value, output parse_error, input ready);
  modport sink   (input valid, input value, input parse_error, output ready);
endinterface

@@ rtl/decimal_field_extractor_top.sv @@
// ---------------------------------------------------------------------------
// Decimal field extractor
// Pulls decimal integers out of a byte stream; one integer or four packed
// as a dotted address, with an error flag when too few are found.
// ---------------------------------------------------------------------------
//  port       dir  handshake     carries
//  req_i      in   valid/ready   char_code, has_char, last
//  res_o      out  valid/ready   value, parse_error (one per string)
//  cfg_*_i    in   write enable  quad_mode
//
//  One request per cycle sustained; a last request passes the input register,
//  then the result register, from which its result is offered.
//  Reset clears the scan state and sets quad mode.
//  A held result stalls a last request in the input register; requests behind it then wait too.
// ---------------------------------------------------------------------------
module decimal_field_extractor_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  dfe_in_if.sink        req_i,
  dfe_out_if.source     res_o
);

  logic                           quad_mode_q;
  logic                           s1_valid_q;
  logic [dfe_pkg::CharWidth-1:0]  s1_char_q;
  logic                           s1_has_char_q;
  logic                           s1_last_q;
  dfe_pkg::scan_state_t           state_q;
  dfe_pkg::scan_state_t           state_d;
  logic                           out_valid_q;
  logic [dfe_pkg::ValueWidth-1:0] out_value_q;
  logic                           out_err_q;
  logic [dfe_pkg::ValueWidth-1:0] step_value;
  logic                           step_err;
  logic                           out_free;
  logic                           s1_advance;
  logic                           req_take;

  dfe_step u_step (
    .st_i          (state_q),
    .char_code_i   (s1_char_q),
    .has_char_i    (s1_has_char_q),
    .last_i        (s1_last_q),
    .quad_mode_i   (quad_mode_q),
    .st_o          (state_d),
    .value_o       (step_value),
    .parse_error_o (step_err)
  );

  assign out_free   = !out_valid_q || res_o.ready;
  assign s1_advance = s1_valid_q && (!s1_last_q || out_free);
  assign req_i.ready = !s1_valid_q || s1_advance;
  assign req_take   = req_i.valid && req_i.ready;

  assign res_o.valid       = out_valid_q;
  assign res_o.value       = out_value_q;
  assign res_o.parse_error = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_mode_q <= dfe_pkg::QuadReset;
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quad_mode_q <= cfg_wdata_i;
      end
      if (req_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        state_q <= state_d;
      end
      if (s1_advance && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      s1_char_q     <= req_i.char_code;
      s1_has_char_q <= req_i.has_char;
      s1_last_q     <= req_i.last;
    end
    if (s1_advance && s1_last_q) begin
      out_value_q <= step_value;
      out_err_q   <= step_err;
    end
  end

endmodule

@@ rtl/dfe_step.sv @@
// ---------------------------------------------------------------------------
// Decimal field extractor step
// Per-character scan update: digit accumulate, field completion and packing,
// end-of-string result and state clear.
// ---------------------------------------------------------------------------
module dfe_step (
  input  dfe_pkg::scan_state_t             st_i,
  input  logic [dfe_pkg::CharWidth-1:0]    char_code_i,
  input  logic                             has_char_i,
  input  logic                             last_i,
  input  logic                             quad_mode_i,
  output dfe_pkg::scan_state_t             st_o,
  output logic [dfe_pkg::ValueWidth-1:0]   value_o,
  output logic                             parse_error_o
);

  logic [dfe_pkg::CountWidth-1:0] need;
  logic                           is_digit;
  logic                           active;
  logic                           do_digit;
  logic                           do_complete;
  logic [3:0]                     digit;
  logic [dfe_pkg::ValueWidth-1:0] acc1;
  logic                           in1;
  logic [dfe_pkg::ValueWidth-1:0] shifted;
  logic [dfe_pkg::ValueWidth-1:0] pk2;
  logic [dfe_pkg::CountWidth-1:0] fd2;
  logic                           err;

  always_comb begin
    need     = quad_mode_i ? dfe_pkg::NeedQuad : dfe_pkg::NeedSingle;
    is_digit = (char_code_i >= dfe_pkg::CharZero) && (char_code_i <= dfe_pkg::CharNine);
    active   = has_char_i && (st_i.fields < need);
    do_digit = active && is_digit;
    digit    = 4'(char_code_i - dfe_pkg::CharZero);

    acc1 = do_digit ? ({st_i.acc[28:0], 3'b000} + {st_i.acc[30:0], 1'b0} + {28'd0, digit})
                    : st_i.acc;
    in1  = do_digit | st_i.in_num;

    do_complete = (active && !is_digit && st_i.in_num) ||
                  (last_i && in1 && (st_i.fields < need));

    case (st_i.fields[1:0])
      2'd0:    shifted = {acc1[7:0], 24'd0};
      2'd1:    shifted = {acc1[15:0], 16'd0};
      2'd2:    shifted = {acc1[23:0], 8'd0};
      default: shifted = acc1;
    endcase

    pk2 = st_i.packed_val;
    fd2 = st_i.fields;
    if (do_complete && (st_i.fields < dfe_pkg::NeedQuad)) begin
      if (quad_mode_i) begin
        pk2 = st_i.packed_val | shifted;
      end else if (st_i.fields == '0) begin
        pk2 = acc1;
      end
      fd2 = st_i.fields + 3'd1;
    end

    err           = fd2 < need;
    value_o       = err ? '0 : pk2;
    parse_error_o = err;

    if (last_i) begin
      st_o = '0;
    end else if (do_complete) begin
      st_o.acc        = '0;
      st_o.in_num     = 1'b0;
      st_o.fields     = fd2;
      st_o.packed_val = pk2;
    end else begin
      st_o.acc        = acc1;
      st_o.in_num     = in1;
      st_o.fields     = st_i.fields;
      st_o.packed_val = st_i.packed_val;
    end
  end

endmodule
